### rtl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

  localparam int FmtW = 4;

  localparam logic [FmtW-1:0] FMT_ARGB8888 = 4'd0;
  localparam logic [FmtW-1:0] FMT_RGBA8888 = 4'd1;
  localparam logic [FmtW-1:0] FMT_BGRA8888 = 4'd2;
  localparam logic [FmtW-1:0] FMT_RGB24    = 4'd3;
  localparam logic [FmtW-1:0] FMT_BGR24    = 4'd4;
  localparam logic [FmtW-1:0] FMT_RGB565   = 4'd5;
  localparam logic [FmtW-1:0] FMT_ARGB1555 = 4'd6;
  localparam logic [FmtW-1:0] FMT_RGBA4444 = 4'd7;
  localparam logic [FmtW-1:0] FMT_GRAY8    = 4'd8;

  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_TARGET_FORMAT = 1'b1;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_in;
  } pfc_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_out;
  } pfc_out_t;

endpackage

`default_nettype wire

### rtl/pixel_format_converter.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_word_i   (pfc_in_t)
// out       output     out_valid_o / out_ready_i  out_word_o  (pfc_out_t)
// config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A word passes an input register and then a result register; out_valid_o rises
// when it reaches the result register. One word can be accepted every cycle while
// the output does not stall. A single conversion stage lies between the registers.
// When the output stalls, both registers fill and in_ready_o drops after that.
// Reset clears both valid flags and sets both format registers to ARGB8888.

module pixel_format_converter
  import pfc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire pfc_in_t        in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pfc_out_t            out_word_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [FmtW-1:0] src_fmt_q, dst_fmt_q;
  logic            cfg_wr;
  logic            s1_valid_q, s2_valid_q;
  pfc_in_t         s1_q;
  pfc_out_t        s2_q;
  logic            s1_load, s2_load;
  logic [31:0]     conv_pixel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FMT_ARGB8888;
      dst_fmt_q <= FMT_ARGB8888;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SOURCE_FORMAT) begin
        src_fmt_q <= pwdata[FmtW-1:0];
      end else begin
        dst_fmt_q <= pwdata[FmtW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SOURCE_FORMAT) ? {28'h0, src_fmt_q} : {28'h0, dst_fmt_q};

  assign s2_load    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !s2_valid_q || out_ready_i;
  assign s1_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= in_word_i;
    end
    if (s2_load) begin
      s2_q.pixel_out <= conv_pixel;
      s2_q.last_out  <= s1_q.last_in;
    end
  end

  pfc_convert u_convert (
    .src_fmt_i (src_fmt_q),
    .dst_fmt_i (dst_fmt_q),
    .pixel_i   (s1_q.pixel_in),
    .pixel_o   (conv_pixel)
  );

  assign out_valid_o = s2_valid_q;
  assign out_word_o  = s2_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> s1_valid_q)
    else $error("accepted word did not reach the input register");

  a_s2_load_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o && (out_word_o.last_out == $past(s1_q.last_in)))
    else $error("result register lost a word or its last flag");

  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && !out_ready_i)
    else $error("input stalled while the pipeline had room");

  a_src_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (paddr[2] == REG_SOURCE_FORMAT) |=> src_fmt_q == $past(pwdata[FmtW-1:0]))
    else $error("source format register not written");

endmodule

`default_nettype wire

### rtl/pfc_convert.sv
`default_nettype none

module pfc_convert
  import pfc_pkg::*;
(
  input  wire logic [FmtW-1:0] src_fmt_i,
  input  wire logic [FmtW-1:0] dst_fmt_i,
  input  wire logic [31:0]     pixel_i,
  output logic      [31:0]     pixel_o
);

  localparam logic [23:0] LumaR = 24'd19595;
  localparam logic [23:0] LumaG = 24'd38470;
  localparam logic [23:0] LumaB = 24'd7471;

  logic [7:0]  a, r, g, b;
  logic [15:0] w;
  logic [23:0] luma;

  assign w = pixel_i[15:0];

  always_comb begin
    a = 8'hFF;
    r = pixel_i[15:8];
    g = pixel_i[23:16];
    b = pixel_i[31:24];
    case (src_fmt_i)
      FMT_RGBA8888: begin
        r = pixel_i[7:0];
        g = pixel_i[15:8];
        b = pixel_i[23:16];
        a = pixel_i[31:24];
      end
      FMT_BGRA8888: begin
        b = pixel_i[7:0];
        g = pixel_i[15:8];
        r = pixel_i[23:16];
        a = pixel_i[31:24];
      end
      FMT_RGB24: begin
        r = pixel_i[7:0];
        g = pixel_i[15:8];
        b = pixel_i[23:16];
      end
      FMT_BGR24: begin
        b = pixel_i[7:0];
        g = pixel_i[15:8];
        r = pixel_i[23:16];
      end
      FMT_RGB565: begin
        r = {w[15:11], w[15:13]};
        g = {w[10:5], w[10:9]};
        b = {w[4:0], w[4:2]};
      end
      FMT_ARGB1555: begin
        r = {w[14:10], 3'b000};
        g = {w[9:5], 3'b000};
        b = {w[4:0], 3'b000};
        a = {8{w[15]}};
      end
      FMT_RGBA4444: begin
        r = {w[15:12], 4'h0};
        g = {w[11:8], 4'h0};
        b = {w[7:4], 4'h0};
        a = {w[3:0], 4'h0};
      end
      FMT_GRAY8: begin
        r = pixel_i[7:0];
        g = pixel_i[7:0];
        b = pixel_i[7:0];
      end
      default: begin
        a = pixel_i[7:0];
      end
    endcase
  end

  // The weights sum to 65536, so the sum never exceeds 24 bits.
  assign luma = LumaR * {16'h0, r} + LumaG * {16'h0, g} + LumaB * {16'h0, b};

  always_comb begin
    case (dst_fmt_i)
      FMT_RGBA8888: pixel_o = {a, b, g, r};
      FMT_BGRA8888: pixel_o = {a, r, g, b};
      FMT_RGB24:    pixel_o = {8'h00, b, g, r};
      FMT_BGR24:    pixel_o = {8'h00, r, g, b};
      FMT_RGB565:   pixel_o = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_ARGB1555: pixel_o = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
      FMT_RGBA4444: pixel_o = {16'h0000, r[7:4], g[7:4], b[7:4], a[7:4]};
      FMT_GRAY8:    pixel_o = {24'h000000, luma[23:16]};
      default:      pixel_o = {b, g, r, a};
    endcase
  end

endmodule

`default_nettype wire
